@@ rtl/cisf_pkg.sv @@
// ----------------------------------------------------------------------------
// cisf_pkg
// Shared types, constants and helpers of the case-insensitive substring find.
// ----------------------------------------------------------------------------
package cisf_pkg;

  localparam int unsigned MAX_NEEDLE_DEF    = 16;
  localparam int unsigned POSITION_BITS_DEF = 16;

  // Needle bytes that can be held by the configuration registers
  localparam int unsigned NEEDLE_BYTES = 16;
  localparam int unsigned NSEL_W       = 4;   // index into the needle bytes
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned OFS_W        = 16;
  localparam int unsigned MSTART_W     = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 64;
  // Width of lane and needle index arithmetic; covers MAX_NEEDLE up to 64
  localparam int unsigned LANE_W       = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFS = 2'd3;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [NEEDLE_BYTES-1:0][7:0] needle;    // folded needle bytes
    logic [LEN_W-1:0]             len;
    logic [OFS_W-1:0]             start_ofs;
  } cfg_t;

  // ASCII upper case to lower case
  function automatic byte_t fold(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ rtl/cisf_if.sv @@
// ----------------------------------------------------------------------------
// cisf_if
// Valid/ready channels of the substring find: haystack, result, configuration.
// ----------------------------------------------------------------------------
interface cisf_hay_if;
  import cisf_pkg::*;
  logic  valid;
  logic  ready;
  byte_t hay_byte;
  logic  last_byte;

  modport source (output valid, output hay_byte, output last_byte, input ready);
  modport sink   (input valid, input hay_byte, input last_byte, output ready);
endinterface

interface cisf_res_if;
  import cisf_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [MSTART_W-1:0] match_start;

  modport source (output valid, output found, output match_start, input ready);
  modport sink   (input valid, input found, input match_start, output ready);
endinterface

interface cisf_cfg_if;
  import cisf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/cisf_cfg.sv @@
// ----------------------------------------------------------------------------
// cisf_cfg
// Configuration registers; needle bytes are stored already folded.
// ----------------------------------------------------------------------------
module cisf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_i,
  input  logic [cisf_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [cisf_pkg::CFG_DATA_W-1:0] data_i,
  output cisf_pkg::cfg_t                  cfg_o
);
  import cisf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (idx_i)
        REG_NEEDLE_LO: begin
          for (int b = 0; b < 8; b++) begin
            cfg_d.needle[b] = fold(data_i[8*b +: 8]);
          end
        end
        REG_NEEDLE_HI: begin
          for (int b = 0; b < 8; b++) begin
            cfg_d.needle[8+b] = fold(data_i[8*b +: 8]);
          end
        end
        REG_NEEDLE_LEN: cfg_d.len       = data_i[LEN_W-1:0];
        REG_START_OFS:  cfg_d.start_ofs = data_i[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/cisf_cell.sv @@
// ----------------------------------------------------------------------------
// cisf_cell
// One window cell: hold a folded byte, pass it on, compare it to its needle byte.
// ----------------------------------------------------------------------------
module cisf_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,     // shift in the neighbor's byte
  input  logic            clr_i,     // end of haystack
  input  cisf_pkg::byte_t byte_i,
  input  cisf_pkg::byte_t needle_i,
  input  logic            active_i,  // lane lies inside the needle
  output cisf_pkg::byte_t byte_o,
  output logic            hit_o
);
  import cisf_pkg::*;

  byte_t byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (clr_i) begin
      byte_q <= '0;
    end else if (adv_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = !active_i || (byte_q == needle_i);

endmodule

@@ rtl/case_insensitive_substring_find.sv @@
// ----------------------------------------------------------------------------
// case_insensitive_substring_find
// Streams haystack bytes through a row of window cells and reports the first
// case-insensitive needle match at or after the start offset, or a miss.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                     | beat means
//  ---------+-----+-----------------------------+--------------------------------
//  hay_i    | in  | hay_byte[7:0], last_byte    | one haystack byte
//  res_o    | out | found, match_start[15:0]    | one hit or one miss per haystack
//  cfg_i    | in  | index[1:0], data[63:0]      | one register write, always ready
//
//  One haystack beat per cycle while hay_i is ready. Every cell of the row compares its byte to
//  its needle byte in the cycle the new byte arrives; the AND across the row
//  and the offset check decide a hit in that same cycle.
//  A result is registered in the output slot, or in the skid slot while res_o stalls.
//  Two result slots (output register plus skid) let hay_i keep flowing while
//  res_o stalls; hay_i drops ready only once both slots hold results.
//  Reset clears the window, the position count, the done flag and the
//  registers (needle length zero, so every haystack ends in a miss).
// ----------------------------------------------------------------------------
module case_insensitive_substring_find #(
  parameter int unsigned MAX_NEEDLE    = cisf_pkg::MAX_NEEDLE_DEF,
  parameter int unsigned POSITION_BITS = cisf_pkg::POSITION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cisf_hay_if.sink   hay_i,
  cisf_res_if.source res_o,
  cisf_cfg_if.sink   cfg_i
);
  import cisf_pkg::*;

  // Wide enough for position + 1 and for the 16-bit start offset
  localparam int unsigned CMP_W = ((POSITION_BITS > OFS_W) ? POSITION_BITS : OFS_W) + 1;

  // ---- configuration ------------------------------------------------------
  cfg_t cfg;

  assign cfg_i.ready = 1'b1;

  cisf_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_i.valid),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  // ---- input beat -------------------------------------------------------
  logic  hay_fire;
  logic  adv;
  logic  clr;
  byte_t cur_fold;

  assign hay_fire = hay_i.valid && hay_i.ready;
  assign adv      = hay_fire && !hay_i.last_byte;
  assign clr      = hay_fire && hay_i.last_byte;
  assign cur_fold = fold(hay_i.hay_byte);

  // ---- needle lanes -------------------------------------------------------
  // Lane 0 is the incoming byte, lane j the byte seen j beats earlier.
  // Lane j compares against needle byte len-1-j and counts only for j < len.
  byte_t              lane_byte   [MAX_NEEDLE];
  byte_t              lane_needle [MAX_NEEDLE];
  logic  [MAX_NEEDLE-1:0] lane_act;
  logic  [MAX_NEEDLE-1:0] lane_hit;

  assign lane_byte[0] = cur_fold;

  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_lane
    logic [LANE_W-1:0] nidx;

    assign lane_act[j] = LANE_W'(j) < LANE_W'(cfg.len);
    assign nidx        = LANE_W'(cfg.len) - LANE_W'(1) - LANE_W'(j);
    assign lane_needle[j] = (nidx < LANE_W'(NEEDLE_BYTES)) ?
                            cfg.needle[nidx[NSEL_W-1:0]] : '0;

    if (j == 0) begin : g_head
      assign lane_hit[j] = !lane_act[j] || (cur_fold == lane_needle[j]);
    end else begin : g_cell
      cisf_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .adv_i    (adv),
        .clr_i    (clr),
        .byte_i   (lane_byte[j-1]),
        .needle_i (lane_needle[j]),
        .active_i (lane_act[j]),
        .byte_o   (lane_byte[j]),
        .hit_o    (lane_hit[j])
      );
    end
  end

  // ---- position and decision ---------------------------------------------
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     done_q, done_d;
  logic [CMP_W-1:0]         pos_next;
  logic [CMP_W-1:0]         start;
  logic                     len_ok;
  logic                     hit;
  logic                     emit;

  assign len_ok   = (cfg.len != '0) && (LANE_W'(cfg.len) <= LANE_W'(MAX_NEEDLE));
  assign pos_next = CMP_W'(pos_q) + CMP_W'(1);
  assign start    = pos_next - CMP_W'(cfg.len);
  assign hit      = hay_fire && !done_q && len_ok
                    && (pos_next >= CMP_W'(cfg.len))
                    && (start >= CMP_W'(cfg.start_ofs))
                    && (&lane_hit);
  // A miss goes out at the last byte when this haystack never hit
  assign emit     = hit || (clr && !done_q);

  always_comb begin
    pos_d  = pos_q;
    done_d = done_q;
    if (clr) begin
      pos_d  = '0;
      done_d = 1'b0;
    end else if (adv) begin
      if (pos_q != '1) begin
        pos_d = pos_q + POSITION_BITS'(1);
      end
      done_d = done_q || hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      done_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  // ---- result slots: output register plus skid ---------------------------
  logic                out_vld_q, out_vld_d;
  logic                out_found_q, out_found_d;
  logic [MSTART_W-1:0] out_start_q, out_start_d;
  logic                skid_vld_q, skid_vld_d;
  logic                skid_found_q, skid_found_d;
  logic [MSTART_W-1:0] skid_start_q, skid_start_d;
  logic                out_fire;
  logic [MSTART_W-1:0] new_start;

  assign out_fire  = out_vld_q && res_o.ready;
  assign new_start = hit ? start[MSTART_W-1:0] : '0;
  // Take beats as long as the skid slot is free
  assign hay_i.ready = !skid_vld_q;

  always_comb begin
    out_vld_d    = out_vld_q;
    out_found_d  = out_found_q;
    out_start_d  = out_start_q;
    skid_vld_d   = skid_vld_q;
    skid_found_d = skid_found_q;
    skid_start_d = skid_start_q;
    if (skid_vld_q) begin
      // Input is held off; advance the skid result when the output drains
      if (out_fire) begin
        out_found_d = skid_found_q;
        out_start_d = skid_start_q;
        skid_vld_d  = 1'b0;
      end
    end else if (emit) begin
      if (!out_vld_q || out_fire) begin
        out_vld_d   = 1'b1;
        out_found_d = hit;
        out_start_d = new_start;
      end else begin
        skid_vld_d   = 1'b1;
        skid_found_d = hit;
        skid_start_d = new_start;
      end
    end else if (out_fire) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q  <= out_found_d;
    out_start_q  <= out_start_d;
    skid_found_q <= skid_found_d;
    skid_start_q <= skid_start_d;
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.found       = out_found_q;
  assign res_o.match_start = out_start_q;

endmodule

@@ rtl/cisf_chk.sv @@
// ----------------------------------------------------------------------------
// cisf_chk
// Port-level checks of the substring find, bound to the top level.
// ----------------------------------------------------------------------------
module cisf_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          hay_valid_i,
  input logic                          hay_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic                          res_found_i,
  input logic [cisf_pkg::MSTART_W-1:0] res_start_i
);
  import cisf_pkg::*;

  // A stalled result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_found_i) && $stable(res_start_i))
    else $error("result payload changed while stalled");

  // A result only follows an accepted haystack beat or an earlier result
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !$past(res_valid_i) |-> $past(hay_valid_i && hay_ready_i))
    else $error("result without a haystack beat");

  // Input backpressure only once results are queued
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hay_ready_i |-> res_valid_i)
    else $error("haystack stalled with no result pending");

  // A miss carries a zero start
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_found_i |-> res_start_i == '0)
    else $error("miss with nonzero start");

endmodule

bind case_insensitive_substring_find cisf_chk u_cisf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .hay_valid_i (hay_i.valid),
  .hay_ready_i (hay_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_found_i (res_o.found),
  .res_start_i (res_o.match_start)
);
